### sv/gpi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpi_pkg
// Shared constants and types for the GF(2) polynomial inverse block.
// ----------------------------------------------------------------------------
package gpi_pkg;

    // Width of the operand, result and modulus register fields
    localparam int FIELD_W = 16;

    // Default modulus degree
    localparam int POLY_DEGREE_DEF = 16;

    // Low modulus coefficients after reset (x^16 + x^12 + x^3 + x + 1)
    localparam logic [FIELD_W-1:0] MODULUS_RESET = 16'h100B;

    // Per-cycle command broadcast to every cell of a chain
    typedef struct packed {
        logic load;  // take the load bits
        logic sh0;   // shift lane 0 up by one
        logic sh1;   // shift lane 1 up by one
        logic xr;    // lane 0 picks up lane 1
        logic sw;    // exchange lanes
    } ctrl_t;

endpackage

### sv/gpi_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpi_if
// Valid/ready channels of the GF(2) polynomial inverse block.
// ----------------------------------------------------------------------------
interface gpi_src_if;
    logic                        valid;
    logic                        ready;
    logic [gpi_pkg::FIELD_W-1:0] operand;

    modport source (output valid, output operand, input ready);
    modport sink (input valid, input operand, output ready);
endinterface

interface gpi_res_if;
    logic                        valid;
    logic                        ready;
    logic [gpi_pkg::FIELD_W-1:0] inverse;

    modport source (output valid, output inverse, input ready);
    modport sink (input valid, input inverse, output ready);
endinterface

interface gpi_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [gpi_pkg::FIELD_W-1:0] modulus_low;

    modport source (output valid, output modulus_low, input ready);
    modport sink (input valid, input modulus_low, output ready);
endinterface

### sv/gpi_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpi_cell
// One bit column of two polynomial lanes; shifts take the neighbor's bit.
// ----------------------------------------------------------------------------
module gpi_cell
(
    input  logic           clk,
    input  gpi_pkg::ctrl_t ctl,
    input  logic           ld0,
    input  logic           ld1,
    input  logic           in0,
    input  logic           in1,
    output logic           b0,
    output logic           b1
);

    logic b0_reg;
    logic b1_reg;
    logic b0_next;
    logic b1_next;

    // Pick the next bit pair from the broadcast command
    always_comb
    begin
        priority if (ctl.load)
        begin
            b0_next = ld0;
            b1_next = ld1;
        end
        else if (ctl.sh0 || ctl.sh1)
        begin
            b0_next = ctl.sh0 ? in0 : b0_reg;
            b1_next = ctl.sh1 ? in1 : b1_reg;
        end
        else
        begin
            b0_next = ctl.xr ? (b0_reg ^ b1_reg) : (ctl.sw ? b1_reg : b0_reg);
            b1_next = ctl.sw ? b0_reg : b1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b0_reg <= b0_next;
        b1_reg <= b1_next;
    end

    assign b0 = b0_reg;
    assign b1 = b1_reg;

endmodule

### sv/gpi_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpi_chain
// Row of bit cells holding two polynomial lanes, linked for upward shifts.
// ----------------------------------------------------------------------------
module gpi_chain
#(
    parameter int WIDTH = 17
)
(
    input  logic             clk,
    input  gpi_pkg::ctrl_t   ctl,
    input  logic [WIDTH-1:0] ld0,
    input  logic [WIDTH-1:0] ld1,
    output logic [WIDTH-1:0] b0,
    output logic [WIDTH-1:0] b1
);

    // Feed each cell with its lower neighbor; the bottom cell takes zero
    logic [WIDTH-1:0] in0;
    logic [WIDTH-1:0] in1;

    assign in0 = {b0[WIDTH-2:0], 1'b0};
    assign in1 = {b1[WIDTH-2:0], 1'b0};

    for (genvar i = 0; i < WIDTH; i++)
    begin : g_cell
        gpi_cell u_cell
        (
            .clk (clk),
            .ctl (ctl),
            .ld0 (ld0[i]),
            .ld1 (ld1[i]),
            .in0 (in0[i]),
            .in1 (in1[i]),
            .b0  (b0[i]),
            .b1  (b1[i])
        );
    end

endmodule

### sv/gf2_poly_modular_inverse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf2_poly_modular_inverse
// Inverse of a GF(2) polynomial modulo x^POLY_DEGREE + modulus_low.
// ----------------------------------------------------------------------------
// Takes one operand at a time and runs an extended Euclid in two rows of bit
// cells: one row holds the two remainders left-aligned, the other holds the
// matching cofactors. Each cycle performs one Euclid step, either a
// normalizing shift, a lane exchange or a reduction; only the finishing
// step can be held, while an earlier result still waits for the sink. An
// item runs from its accept step through the normalizing shifts, lane
// exchanges and reductions to the finishing step, and the number of steps
// it takes grows with the number of reductions that the operand needs. A
// finished result sits in an output register, and the next operand is
// accepted while it waits. That operand cannot finish until the sink takes
// the earlier beat.
// The inverse is 0 for a zero operand or one sharing a factor with the
// modulus. Write modulus_low only while the block is idle.
// ----------------------------------------------------------------------------
module gf2_poly_modular_inverse
#(
    parameter int POLY_DEGREE = gpi_pkg::POLY_DEGREE_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    gpi_src_if.sink       src,
    gpi_res_if.source     res,
    gpi_cfg_if.sink       cfg
);

    localparam int N   = POLY_DEGREE;
    localparam int FW  = gpi_pkg::FIELD_W;
    localparam int DW  = $clog2(N + 1);
    localparam int TW  = 2 * N + 1;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic          state_reg;
    logic          state_next;
    logic [DW-1:0] d0_reg;
    logic [DW-1:0] d0_next;
    logic [DW-1:0] d1_reg;
    logic [DW-1:0] d1_next;
    logic [FW-1:0] modulus_low_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [FW-1:0] inverse_reg;
    logic [FW-1:0] inverse_next;

    gpi_pkg::ctrl_t ctl;
    logic           src_beat;
    logic           fin;

    logic [N:0]    r0;
    logic [N:0]    r1;
    logic [TW-1:0] t0;
    logic [TW-1:0] t1;
    logic [N:0]    r0_ld;
    logic [N:0]    r1_ld;
    logic [TW-1:0] t1_ld;

    logic [N+FW:0]  op_x;
    logic [N+FW:0]  mod_x;
    logic [TW+FW-1:0] t0_x;

    logic r0z;
    logic r1z;
    logic n0;
    logic n1;

    // Mask operand and modulus to the degree and align the load words
    assign op_x  = {{(N + 1){1'b0}}, src.operand};
    assign mod_x = {{(N + 1){1'b0}}, modulus_low_reg};
    assign r0_ld = {1'b1, mod_x[N-1:0]};
    assign r1_ld = {1'b0, op_x[N-1:0]};
    assign t1_ld = {{(TW - 1){1'b0}}, 1'b1};

    // Remainder and cofactor rows
    gpi_chain #(.WIDTH(N + 1)) u_rem
    (
        .clk (clk),
        .ctl (ctl),
        .ld0 (r0_ld),
        .ld1 (r1_ld),
        .b0  (r0),
        .b1  (r1)
    );

    gpi_chain #(.WIDTH(TW)) u_cof
    (
        .clk (clk),
        .ctl (ctl),
        .ld0 ({TW{1'b0}}),
        .ld1 (t1_ld),
        .b0  (t0),
        .b1  (t1)
    );

    assign r0z = ~|r0;
    assign r1z = ~|r1;
    assign n0  = !r0z && !r0[N];
    assign n1  = !r1z && !r1[N];

    assign src_beat = src.valid && src.ready;
    assign src.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    // Read the inverse out of the top half of the cofactor
    assign t0_x = {{FW{1'b0}}, t0};
    assign inverse_next = (d0_reg == '0 && !r0z) ? t0_x[N +: FW] : '0;

    // Sequence one Euclid step per cycle; the finishing step may wait for the sink to take the earlier result
    always_comb
    begin
        ctl        = '0;
        fin        = 1'b0;
        state_next = state_reg;
        d0_next    = d0_reg;
        d1_next    = d1_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (src_beat)
                begin
                    ctl.load   = 1'b1;
                    d0_next    = DW'(N);
                    d1_next    = DW'(N);
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                priority if (n0 || n1)
                begin
                    ctl.sh0 = n0;
                    ctl.sh1 = n1;
                    if (n0)
                    begin
                        d0_next = d0_reg - 1'b1;
                    end
                    if (n1)
                    begin
                        d1_next = d1_reg - 1'b1;
                    end
                end
                else if (r1z)
                begin
                    if (!out_valid_reg || res.ready)
                    begin
                        fin        = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (r0z)
                begin
                    ctl.sw  = 1'b1;
                    d0_next = d1_reg;
                    d1_next = d0_reg;
                end
                else if (d0_reg < d1_reg)
                begin
                    ctl.sw  = 1'b1;
                    ctl.xr  = 1'b1;
                    d0_next = d1_reg;
                    d1_next = d0_reg;
                end
                else
                begin
                    ctl.xr = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the result until the sink takes the beat
    assign out_valid_next = fin ? 1'b1 : (res.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            out_valid_reg   <= 1'b0;
            modulus_low_reg <= gpi_pkg::MODULUS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                modulus_low_reg <= cfg.modulus_low;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        d0_reg <= d0_next;
        d1_reg <= d1_next;
        if (fin)
        begin
            inverse_reg <= inverse_next;
        end
    end

    assign res.valid   = out_valid_reg;
    assign res.inverse = inverse_reg;

endmodule

### sv/gpi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpi_checker
// Port-level checks for the GF(2) polynomial inverse block.
// ----------------------------------------------------------------------------
module gpi_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        src_valid,
    input logic                        src_ready,
    input logic                        res_valid,
    input logic                        res_ready,
    input logic [gpi_pkg::FIELD_W-1:0] inverse,
    input logic                        cfg_ready
);

    // Hold a result beat until it is taken
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result beat dropped while stalled");

    // Keep the stalled payload steady
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(inverse))
        else $error("result payload changed while stalled");

    // Go busy right after taking an operand
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && src_ready |=> !src_ready)
        else $error("operand accepted while still busy");

    // Always take register writes
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind gf2_poly_modular_inverse gpi_checker u_gpi_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (src.valid),
    .src_ready (src.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .inverse   (res.inverse),
    .cfg_ready (cfg.ready)
);
